FILE: hw/rtl/esv_pkg.sv
// Shared types and constants for the prime sieve block.
// No dependencies; imported by every module of the block.
`default_nettype none
package esv_pkg;

  localparam int ESV_MAX_LIMIT = 255;
  localparam int LIMIT_W       = 8;
  localparam int PRIME_W       = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMPTY,
    ST_INIT,
    ST_RD_I,
    ST_CHK_I,
    ST_STRIKE,
    ST_ADV_SQ,
    ST_ADV_I,
    ST_SCAN,
    ST_SCAN_END,
    ST_FLUSH
  } esv_state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/esv_alu.sv
// Shared adder with carry-in and a compare of the sum against the limit.
// Depends on esv_pkg.
`default_nettype none
module esv_alu
  import esv_pkg::*;
#(
  parameter int W = 10
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  input  wire logic         cin,
  input  wire logic [W-1:0] lim,
  output logic      [W-1:0] sum,
  output logic              le
);

  assign sum = a + b + W'(cin);
  assign le  = (sum <= lim);

endmodule
`default_nettype wire

FILE: hw/rtl/esv_map.sv
// Candidate bitmap: single-port memory, one bit per entry, registered read.
// Depends on esv_pkg.
`default_nettype none
module esv_map
  import esv_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic          wdata,
  output logic               rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/eratosthenes_prime_sieve.sv
// Prime sieve top level: sequencer, shared adder and candidate bitmap.
// One request at a time; busy drops as the last result appears.
// The bitmap fill, the strike loop and the scan share one adder and one memory port.
// Reset (rst_n low, synchronous) returns to idle and drops any result in flight.
// Results appear as one-cycle strobes; the receiver cannot stall.
`default_nettype none
module eratosthenes_prime_sieve
  import esv_pkg::*;
#(
  parameter int MAX_LIMIT = ESV_MAX_LIMIT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [LIMIT_W-1:0] in_limit,
  output logic                    out_valid,
  output logic [PRIME_W-1:0]      out_prime,
  output logic                    out_is_last,
  output logic                    out_empty_res
);

  // Address width covers entries 0..MAX_LIMIT; one extra bit lets running
  // sums (m + i, next square) overshoot the limit without wrapping.
  localparam int DEPTH = MAX_LIMIT + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int W     = AW + 1;

  esv_state_t state_r, state_nxt;

  logic [W-1:0] lim_r, lim_nxt;     // saturated limit of this request
  logic [W-1:0] i_r, i_nxt;         // current sieving base
  logic [W-1:0] sq_r, sq_nxt;       // i * i, kept by increments
  logic [W-1:0] m_r, m_nxt;         // multiple being struck
  logic [W-1:0] j_r, j_nxt;         // fill / scan index
  logic [W-1:0] jd_r, jd_nxt;       // index of the read in flight
  logic         rv_r, rv_nxt;       // scan read in flight
  logic [W-1:0] pend_r, pend_nxt;   // last prime found, held for the is_last lookahead
  logic         pend_v_r, pend_v_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [PRIME_W-1:0] out_prime_r, out_prime_nxt;
  logic               out_is_last_r, out_is_last_nxt;
  logic               out_empty_r, out_empty_nxt;

  logic [W-1:0] alu_a, alu_b, alu_sum;
  logic         alu_cin, alu_le;

  logic          mem_we, mem_wd, mem_rd;
  logic [AW-1:0] mem_addr;

  logic [W-1:0] lim_sat;
  logic         accept;
  logic         hit;

  esv_alu #(.W(W)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .cin (alu_cin),
    .lim (lim_r),
    .sum (alu_sum),
    .le  (alu_le)
  );

  esv_map #(.DEPTH(DEPTH), .AW(AW)) u_map (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wd),
    .rdata (mem_rd)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Clamp the request to the bitmap depth.
  assign lim_sat = (32'(in_limit) > MAX_LIMIT) ? W'(MAX_LIMIT) : W'(in_limit);

  // A surviving entry comes back from the scan read.
  assign hit = rv_r && mem_rd;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (lim_sat < W'(2)) ? ST_EMPTY : ST_INIT;
        end
      end
      ST_EMPTY:    state_nxt = ST_IDLE;
      ST_INIT: begin
        if (!alu_le) begin
          state_nxt = ST_RD_I;
        end
      end
      // Square past the limit ends sieving.
      ST_RD_I:     state_nxt = alu_le ? ST_CHK_I : ST_SCAN;
      ST_CHK_I:    state_nxt = mem_rd ? ST_STRIKE : ST_ADV_SQ;
      ST_STRIKE: begin
        if (!alu_le) begin
          state_nxt = ST_ADV_SQ;
        end
      end
      ST_ADV_SQ:   state_nxt = ST_ADV_I;
      ST_ADV_I:    state_nxt = ST_RD_I;
      ST_SCAN: begin
        if (!alu_le) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_nxt = ST_FLUSH;
      ST_FLUSH:    state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control: adder operands, memory port and register updates.
  always_comb begin
    alu_a    = i_r;
    alu_b    = '0;
    alu_cin  = 1'b0;
    mem_we   = 1'b0;
    mem_wd   = 1'b0;
    mem_addr = j_r[AW-1:0];

    lim_nxt    = lim_r;
    i_nxt      = i_r;
    sq_nxt     = sq_r;
    m_nxt      = m_r;
    j_nxt      = j_r;
    jd_nxt     = jd_r;
    rv_nxt     = 1'b0;
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;

    out_valid_nxt   = 1'b0;
    out_prime_nxt   = out_prime_r;
    out_is_last_nxt = 1'b0;
    out_empty_nxt   = 1'b0;

    // Emit the held prime once a later one shows up; it cannot be the last.
    if (hit) begin
      if (pend_v_r) begin
        out_valid_nxt = 1'b1;
        out_prime_nxt = PRIME_W'(pend_r);
      end
      pend_nxt   = jd_r;
      pend_v_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          lim_nxt    = lim_sat;
          j_nxt      = W'(2);
          i_nxt      = W'(2);
          sq_nxt     = W'(4);
          pend_v_nxt = 1'b0;
        end
      end
      ST_EMPTY: begin
        out_valid_nxt   = 1'b1;
        out_prime_nxt   = '0;
        out_is_last_nxt = 1'b1;
        out_empty_nxt   = 1'b1;
      end
      ST_INIT: begin
        // Mark j as a candidate, advance j.
        mem_we   = 1'b1;
        mem_wd   = 1'b1;
        mem_addr = j_r[AW-1:0];
        alu_a    = j_r;
        alu_cin  = 1'b1;
        j_nxt    = alu_sum;
      end
      ST_RD_I: begin
        // Read map[i] while testing i*i against the limit.
        mem_addr = i_r[AW-1:0];
        alu_a    = sq_r;
        m_nxt    = sq_r;
        if (!alu_le) begin
          j_nxt = W'(2);
        end
      end
      ST_CHK_I: begin
        mem_addr = i_r[AW-1:0];
      end
      ST_STRIKE: begin
        // Strike m, advance by i.
        mem_we   = 1'b1;
        mem_wd   = 1'b0;
        mem_addr = m_r[AW-1:0];
        alu_a    = m_r;
        alu_b    = i_r;
        m_nxt    = alu_sum;
      end
      ST_ADV_SQ: begin
        // (i+1)^2 = i^2 + 2i + 1
        alu_a   = sq_r;
        alu_b   = {i_r[W-2:0], 1'b0};
        alu_cin = 1'b1;
        sq_nxt  = alu_sum;
      end
      ST_ADV_I: begin
        alu_a   = i_r;
        alu_cin = 1'b1;
        i_nxt   = alu_sum;
      end
      ST_SCAN: begin
        // One read per cycle; the result is checked in the cycle after.
        mem_addr = j_r[AW-1:0];
        alu_a    = j_r;
        alu_cin  = 1'b1;
        j_nxt    = alu_sum;
        jd_nxt   = j_r;
        rv_nxt   = 1'b1;
      end
      ST_SCAN_END: begin
        mem_addr = j_r[AW-1:0];
      end
      ST_FLUSH: begin
        // The held prime is the final one; two is always found.
        out_valid_nxt   = 1'b1;
        out_prime_nxt   = PRIME_W'(pend_r);
        out_is_last_nxt = 1'b1;
      end
      default: begin
        mem_addr = j_r[AW-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rv_r        <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rv_r        <= rv_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r         <= lim_nxt;
    i_r           <= i_nxt;
    sq_r          <= sq_nxt;
    m_r           <= m_nxt;
    j_r           <= j_nxt;
    jd_r          <= jd_nxt;
    pend_r        <= pend_nxt;
    out_prime_r   <= out_prime_nxt;
    out_is_last_r <= out_is_last_nxt;
    out_empty_r   <= out_empty_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_prime     = out_prime_r;
  assign out_is_last   = out_is_last_r;
  assign out_empty_res = out_empty_r;

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for the prime sieve block: drives limit requests and checks
// every strobed prime, with its last and empty flags, against an in-bench sieve.
// Depends on esv_pkg and eratosthenes_prime_sieve.
`timescale 1ns / 1ps

module tb;
  import esv_pkg::*;

  // The block never emits more primes than this for one request.
  localparam int RESULT_CAP = 54;
  // Several times the length of the slowest request, which is itself longer
  // than the longest silent stretch inside it.
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES = 1000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic               is_last;
    logic               empty_res;
  } prime_res_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic [LIMIT_W-1:0] in_limit = '0;
  logic               busy;
  logic               out_valid;
  logic [PRIME_W-1:0] out_prime;
  logic               out_is_last;
  logic               out_empty_res;

  prime_res_t pending_primes[$];
  int         mismatch_count = 0;
  int         quiet_cycles = 0;
  bit         idle_enable = 1'b1;

  eratosthenes_prime_sieve u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_limit     (in_limit),
    .out_valid    (out_valid),
    .out_prime    (out_prime),
    .out_is_last  (out_is_last),
    .out_empty_res(out_empty_res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Append one expected result at the tail of the pending list.
  function automatic void queue_expected(input prime_res_t res);
    pending_primes.insert(pending_primes.size(), res);
  endfunction

  // Sieve one limit and queue the primes the block should strobe, in order.
  // A limit below two gives a single empty result; an oversize limit saturates.
  function automatic void predict_primes(input logic [LIMIT_W-1:0] lim_in);
    int         lim;
    int         n;
    int         k;
    int         total;
    int         found;
    bit         sieve_map [0:ESV_MAX_LIMIT];
    prime_res_t res;
    lim = int'(lim_in);
    if (lim > ESV_MAX_LIMIT) lim = ESV_MAX_LIMIT;
    if (lim < 2) begin
      res.prime     = '0;
      res.is_last   = 1'b1;
      res.empty_res = 1'b1;
      queue_expected(res);
      return;
    end
    for (n = 0; n <= lim; n++) sieve_map[n] = (n >= 2);
    for (n = 2; n * n <= lim; n++) begin
      if (sieve_map[n]) begin
        for (k = n * n; k <= lim; k += n) sieve_map[k] = 1'b0;
      end
    end
    // Count survivors first so the last flag lands on the right entry.
    total = 0;
    for (n = 2; n <= lim; n++) begin
      if (sieve_map[n] && total < RESULT_CAP) total++;
    end
    found = 0;
    for (n = 2; n <= lim && found < total; n++) begin
      if (sieve_map[n]) begin
        res.prime     = n[PRIME_W-1:0];
        res.is_last   = (found == total - 1);
        res.empty_res = 1'b0;
        queue_expected(res);
        found++;
      end
    end
  endfunction

  // Sample at the edge: predict on each accepted request, then check each strobe
  // against the oldest pending prime. Keep running after a mismatch.
  always @(posedge clk) begin
    prime_res_t want;
    if (rst_n) begin
      if (start && !busy) predict_primes(in_limit);
      if (out_valid) begin
        if (pending_primes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: prime=%0d last=%0b empty=%0b",
                     out_prime, out_is_last, out_empty_res);
        end else begin
          want = pending_primes.pop_front();
          if (out_prime !== want.prime || out_is_last !== want.is_last ||
              out_empty_res !== want.empty_res) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $write("mismatch: expected prime=%0d last=%0b empty=%0b,",
                     want.prime, want.is_last, want.empty_res);
              $display(" got prime=%0d last=%0b empty=%0b",
                       out_prime, out_is_last, out_empty_res);
            end
          end
        end
      end
    end
  end

  // Count cycles in which neither a request nor a result moves; stop a hung run.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one limit request. With idling on, a random gap may be drawn; if so, drop
  // start, wait for the block to go idle and hold off a random number of cycles,
  // so the request lands at any phase after the previous one finished. With no
  // gap, keep start high so the next request waits on busy alone.
  task automatic send_limit(input logic [LIMIT_W-1:0] lim);
    int gap;
    gap = 0;
    while (idle_enable && $urandom_range(0, 99) < 36) gap++;
    if (idle_enable && $urandom_range(0, 19) == 0) gap += $urandom_range(1, 40);
    if (gap > 0) begin
      start <= 1'b0;
      @(posedge clk);
      while (busy) @(posedge clk);
      repeat (gap - 1) @(posedge clk);
    end
    start    <= 1'b1;
    in_limit <= lim;
    // Wait for the edge that accepts it.
    do @(posedge clk); while (busy);
  endtask

  // Corners of the limit: below two, the first primes, perfect squares of
  // sieving primes, a prime limit, the top of the range and alternating bits.
  task automatic test_directed();
    logic [LIMIT_W-1:0] corner_limits [$];
    corner_limits = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd8, 8'd9, 8'd10, 8'd11,
                      8'd25, 8'd49, 8'd121, 8'd169, 8'd211, 8'd255, 8'd254, 8'd128,
                      8'd127, 8'hAA, 8'h55, 8'd36, 8'd97, 8'd0};
    foreach (corner_limits[i]) send_limit(corner_limits[i]);
  endtask

  // Pick a limit: small ones most often, to keep requests short, some near squares,
  // some below two, and a share across the whole range.
  function automatic logic [LIMIT_W-1:0] pick_limit();
    int      pick;
    int      root;
    pick = $urandom_range(0, 99);
    if (pick < 25) return LIMIT_W'($urandom_range(0, 255));
    if (pick < 70) return LIMIT_W'($urandom_range(2, 40));
    if (pick < 88) begin
      root = $urandom_range(2, 15);
      return LIMIT_W'(root * root + $urandom_range(0, 2) - 1);
    end
    return LIMIT_W'($urandom_range(0, 1));
  endfunction

  // Long stretch with no idling: requests queue up behind busy.
  task automatic test_back_to_back();
    idle_enable = 1'b0;
    repeat (25) send_limit(pick_limit());
    idle_enable = 1'b1;
  endtask

  // Random limits with random gaps between requests.
  task automatic test_random();
    repeat (81) send_limit(pick_limit());
  endtask

  // Lower start, wait for every pending prime, then watch for strays.
  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_primes.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_primes.size() != 0) mismatch_count++;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_back_to_back();
    test_random();
    wait_drain();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/esv_pkg.sv
hw/rtl/esv_alu.sv
hw/rtl/esv_map.sv
hw/rtl/eratosthenes_prime_sieve.sv
bench/tb.sv
